### sv/mpsr_pkg.sv
package mpsr_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam int EP_W   = 10;
    localparam int HOP_W  = 4;
    localparam int NODE_W = 7;
    localparam int OWN_W  = 6;
    localparam int HPR_W  = 5;
    localparam int PORT_W = 5;
    localparam int PLL_W  = 4;
    localparam int TR_W   = 6;
    localparam int PS_W   = 2;
    localparam int HS_W   = 4;
    localparam int STAT_W = 3;

    localparam logic [1:0] REQ_PATH_NODE  = 2'd0;
    localparam logic [1:0] REQ_PATH_COUNT = 2'd1;
    localparam logic [1:0] REQ_NBR_PORT   = 2'd2;
    localparam logic [1:0] REQ_ROUTE      = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_PATH_END  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_LINK   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_HOP_LIMIT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NO_PATH   = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ROUTER  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOSTS       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NET_PORTS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATH_LIMIT  = 2'd3;

    localparam logic [NODE_W-1:0] NODE_END = 7'h7F;

    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = EP_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic              done;
        logic [EP_W-1:0]   quot;
        logic [HPR_W-1:0]  rem;
    } t_div_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DECIDE,
        ST_NBR_WAIT,
        ST_DEST_WAIT,
        ST_NODE1_WAIT,
        ST_NBR1_WAIT,
        ST_PATH_WAIT,
        ST_SEND
    } t_state;

endpackage

### sv/mpsr_ram.sv
module mpsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mpsr_div.sv
module mpsr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mpsr_pkg::EP_W-1:0]  i_dividend,
    input  logic [mpsr_pkg::HPR_W-1:0] i_divisor,
    output mpsr_pkg::t_div_res        o_res
);

    import mpsr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [EP_W-1:0]      r_quo;
    logic [HPR_W-1:0]     r_rem;
    logic [HPR_W-1:0]     r_div;
    logic [EP_W-1:0]      n_quo;
    logic [HPR_W-1:0]     n_rem;

    // two restoring steps per cycle
    always_comb begin
        logic [HPR_W:0]   v_t;
        logic [EP_W-1:0]  v_quo;
        logic [HPR_W-1:0] v_rem;
        v_quo = r_quo;
        v_rem = r_rem;
        v_t   = '0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            v_t   = {v_rem, v_quo[EP_W-1]};
            v_quo = {v_quo[EP_W-2:0], 1'b0};
            if (v_t >= {1'b0, r_div}) begin
                v_t      = v_t - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
            v_rem = v_t[HPR_W-1:0];
        end
        n_quo = v_quo;
        n_rem = v_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

### sv/multipath_source_route_table_top.sv
// multipath source route table: output port selector of a network router
//
// s_axis carries requests: tuser is the request kind (path node write, path
// count write, neighbour port write, route), tdata the request fields. Load
// requests give no result. A route request gives one
// result, or on its first hop one result per node of the chosen path
// (path_length_limit + 1 transfers, the limit held to 1..MAX_HOPS; tlast on the final one).
// A route request first passes its endpoint through the endpoint divider
// (two quotient bits per cycle), then reads the neighbour table or the path
// count as the case needs. In a first-hop route, after the first hop's
// neighbour is looked up when there is one, every path node is one read of
// the path memory's single read port. Receiver stalls hold the block up.
// cfg is a write channel, always ready, for the four registers; write it
// only while the block is idle.
// After reset the destination and neighbour tables are cleared, one entry
// a cycle; no request is taken meanwhile.
// m_axis holds one result in an output register; while the receiver stalls
// the block waits with the next result, and a new request is taken only
// once the current one has handed over its final result.
module multipath_source_route_table_top #(
    parameter int MAX_ROUTERS = 64,
    parameter int MAX_PATHS   = 4,
    parameter int MAX_HOPS    = 8,
    parameter int MAX_PORTS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // dest_endpoint, hop_count, carried_next_node, table_router,
    // path_slot, hop_slot, table_value
    input  logic [mpsr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // req_type
    input  logic [mpsr_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_port, out_vc, new_hop_count, path_node, zero fill
    output logic [mpsr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [mpsr_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpsr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mpsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import mpsr_pkg::*;

    localparam int RW          = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
    localparam int PW          = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
    localparam int CNTW        = $clog2(MAX_PATHS + 1);
    localparam int NPW         = $clog2(MAX_PORTS);
    localparam int LIMW        = $clog2(MAX_HOPS + 1);
    localparam int STORE_DEPTH = MAX_ROUTERS * MAX_PATHS * (MAX_HOPS + 1);
    localparam int SAW         = $clog2(STORE_DEPTH);
    localparam int DEST_W      = CNTW + PW;
    localparam int NBR_W       = NPW + 1;

    // configuration registers
    logic [OWN_W-1:0]  r_own;
    logic [HPR_W-1:0]  r_hpr;
    logic [PORT_W-1:0] r_npc;
    logic [PLL_W-1:0]  r_pll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
            r_hpr <= HPR_W'(1);
            r_npc <= PORT_W'(1);
            r_pll <= PLL_W'(8);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_OWN_ROUTER: r_own <= i_cfg_data[OWN_W-1:0];
                CFG_HOSTS:      r_hpr <= i_cfg_data[HPR_W-1:0];
                CFG_NET_PORTS:  r_npc <= i_cfg_data[PORT_W-1:0];
                CFG_PATH_LIMIT: r_pll <= i_cfg_data[PLL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // request fields
    logic [EP_W-1:0]   in_ep;
    logic [HOP_W-1:0]  in_hops;
    logic [NODE_W-1:0] in_carried;
    logic [TR_W-1:0]   in_tr;
    logic [PS_W-1:0]   in_ps;
    logic [HS_W-1:0]   in_hs;
    logic [NODE_W-1:0] in_tv;

    assign in_ep      = i_s_axis_tdata[9:0];
    assign in_hops    = i_s_axis_tdata[13:10];
    assign in_carried = i_s_axis_tdata[20:14];
    assign in_tr      = i_s_axis_tdata[26:21];
    assign in_ps      = i_s_axis_tdata[28:27];
    assign in_hs      = i_s_axis_tdata[32:29];
    assign in_tv      = i_s_axis_tdata[39:33];

    // registers of the sequencer
    t_state            r_state, n_state;
    logic [RW-1:0]     r_clr_idx, n_clr_idx;
    logic [1:0]        r_req_type, n_req_type;
    logic [EP_W-1:0]   r_ep, n_ep;
    logic [HOP_W-1:0]  r_hops, n_hops;
    logic [NODE_W-1:0] r_carried, n_carried;
    logic [TR_W-1:0]   r_tr, n_tr;
    logic [PS_W-1:0]   r_ps, n_ps;
    logic [HS_W-1:0]   r_hs, n_hs;
    logic [NODE_W-1:0] r_tv, n_tv;
    logic [EP_W-1:0]   r_dest, n_dest;
    logic [HPR_W-1:0]  r_rem, n_rem;
    logic [SAW-1:0]    r_base, n_base;
    logic [LIMW-1:0]   r_i, n_i;
    logic [PORT_W-1:0] r_port, n_port;
    logic [HOP_W-1:0]  r_vc, n_vc;
    logic [HOP_W-1:0]  r_nh, n_nh;
    logic [NODE_W-1:0] r_node, n_node;
    logic [STAT_W-1:0] r_st, n_st;
    logic              r_last, n_last;

    // memories
    logic              path_we, path_re;
    logic [SAW-1:0]    path_waddr, path_raddr;
    logic [NODE_W-1:0] path_wdata, path_rdata;
    logic              dest_we, dest_re;
    logic [RW-1:0]     dest_waddr, dest_raddr;
    logic [DEST_W-1:0] dest_wdata, dest_rdata;
    logic              nbr_we, nbr_re;
    logic [RW-1:0]     nbr_waddr, nbr_raddr;
    logic [NBR_W-1:0]  nbr_wdata, nbr_rdata;

    mpsr_ram #(.WIDTH(NODE_W), .DEPTH(STORE_DEPTH)) u_path_mem (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_re    (path_re),
        .i_raddr (path_raddr),
        .o_rdata (path_rdata)
    );

    mpsr_ram #(.WIDTH(DEST_W), .DEPTH(MAX_ROUTERS)) u_dest_mem (
        .i_clk   (i_clk),
        .i_we    (dest_we),
        .i_waddr (dest_waddr),
        .i_wdata (dest_wdata),
        .i_re    (dest_re),
        .i_raddr (dest_raddr),
        .o_rdata (dest_rdata)
    );

    mpsr_ram #(.WIDTH(NBR_W), .DEPTH(MAX_ROUTERS)) u_nbr_mem (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_re    (nbr_re),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    // endpoint divider
    logic             div_start;
    logic [HPR_W-1:0] eff_hpr;
    t_div_res         div_res;

    assign eff_hpr = (r_hpr == '0) ? HPR_W'(1) : r_hpr;

    mpsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_ep),
        .i_divisor  (eff_hpr),
        .o_res      (div_res)
    );

    // derived values
    logic [LIMW-1:0]  eff_lim;
    logic [HOP_W-1:0] nh_sat;
    logic             hop_over;
    logic             carried_bad;
    logic             node1_bad;
    logic [CNTW-1:0]  dest_cnt;
    logic [PW-1:0]    dest_ptr;
    logic [PW-1:0]    sel;
    logic [PW-1:0]    sel_next;
    logic [SAW-1:0]   base_calc;
    logic             out_free;
    logic             out_load;
    logic             r_out_valid;

    always_comb begin
        if (r_pll == '0) begin
            eff_lim = LIMW'(1);
        end else if (int'(r_pll) > MAX_HOPS) begin
            eff_lim = LIMW'(MAX_HOPS);
        end else begin
            eff_lim = LIMW'(r_pll);
        end
    end

    assign nh_sat      = (r_hops == '1) ? r_hops : r_hops + 1'b1;
    assign hop_over    = (int'(r_hops) + 1) > int'(eff_lim);
    assign carried_bad = (int'(r_carried[5:0]) >= MAX_ROUTERS)
                         || (r_carried[5:0] == r_own);
    assign node1_bad   = (int'(path_rdata[5:0]) >= MAX_ROUTERS)
                         || (path_rdata[5:0] == r_own);

    assign dest_cnt  = dest_rdata[DEST_W-1:PW];
    assign dest_ptr  = dest_rdata[PW-1:0];
    assign sel       = (int'(dest_ptr) >= int'(dest_cnt)) ? '0 : dest_ptr;
    assign sel_next  = ((int'(sel) + 1) == int'(dest_cnt)) ? '0 : PW'(int'(sel) + 1);
    assign base_calc = SAW'((int'(r_dest) * MAX_PATHS + int'(sel)) * (MAX_HOPS + 1));
    assign out_free  = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_req_type = r_req_type;
        n_ep       = r_ep;
        n_hops     = r_hops;
        n_carried  = r_carried;
        n_tr       = r_tr;
        n_ps       = r_ps;
        n_hs       = r_hs;
        n_tv       = r_tv;
        n_dest     = r_dest;
        n_rem      = r_rem;
        n_base     = r_base;
        n_i        = r_i;
        n_port     = r_port;
        n_vc       = r_vc;
        n_nh       = r_nh;
        n_node     = r_node;
        n_st       = r_st;
        n_last     = r_last;

        o_s_axis_tready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        path_we    = 1'b0;
        path_waddr = '0;
        path_wdata = r_tv;
        path_re    = 1'b0;
        path_raddr = '0;
        dest_we    = 1'b0;
        dest_waddr = '0;
        dest_wdata = '0;
        dest_re    = 1'b0;
        dest_raddr = '0;
        nbr_we     = 1'b0;
        nbr_waddr  = '0;
        nbr_wdata  = '0;
        nbr_re     = 1'b0;
        nbr_raddr  = '0;

        unique case (r_state)
            ST_CLEAR: begin
                dest_we    = 1'b1;
                dest_waddr = r_clr_idx;
                nbr_we     = 1'b1;
                nbr_waddr  = r_clr_idx;
                if (r_clr_idx == RW'(MAX_ROUTERS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_req_type = i_s_axis_tuser;
                    n_ep       = in_ep;
                    n_hops     = in_hops;
                    n_carried  = in_carried;
                    n_tr       = in_tr;
                    n_ps       = in_ps;
                    n_hs       = in_hs;
                    n_tv       = in_tv;
                    n_state    = (i_s_axis_tuser == REQ_ROUTE) ? ST_DIV_START : ST_LOAD;
                end
            end
            ST_LOAD: begin
                case (r_req_type)
                    REQ_PATH_NODE: begin
                        if (int'(r_tr) < MAX_ROUTERS && int'(r_ps) < MAX_PATHS
                            && int'(r_hs) <= MAX_HOPS) begin
                            path_we    = 1'b1;
                            path_waddr = SAW'((int'(r_tr) * MAX_PATHS + int'(r_ps))
                                              * (MAX_HOPS + 1) + int'(r_hs));
                        end
                    end
                    REQ_PATH_COUNT: begin
                        if (int'(r_tr) < MAX_ROUTERS) begin
                            dest_we    = 1'b1;
                            dest_waddr = RW'(r_tr);
                            if (r_tv[NODE_W-1]) begin
                                dest_wdata = '0;
                            end else if (int'(r_tv) > MAX_PATHS) begin
                                dest_wdata = {CNTW'(MAX_PATHS), PW'(0)};
                            end else begin
                                dest_wdata = {CNTW'(r_tv), PW'(0)};
                            end
                        end
                    end
                    REQ_NBR_PORT: begin
                        if (int'(r_tr) < MAX_ROUTERS) begin
                            nbr_we    = 1'b1;
                            nbr_waddr = RW'(r_tr);
                            if (!r_tv[NODE_W-1] && int'(r_tv) < MAX_PORTS) begin
                                nbr_wdata = {1'b1, NPW'(r_tv[5:0])};
                            end else begin
                                nbr_wdata = '0;
                            end
                        end
                    end
                    default: ;
                endcase
                n_state = ST_IDLE;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    n_dest  = div_res.quot;
                    n_rem   = div_res.rem;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_node = NODE_END;
                n_last = 1'b1;
                n_vc   = r_hops;
                n_port = '0;
                if (r_dest == EP_W'(r_own)) begin
                    n_port  = r_npc + r_rem;
                    n_nh    = r_hops;
                    n_st    = STAT_OK;
                    n_state = ST_SEND;
                end else if (int'(r_dest) >= MAX_ROUTERS) begin
                    n_nh    = r_hops;
                    n_st    = STAT_NO_PATH;
                    n_state = ST_SEND;
                end else if (r_hops != '0) begin
                    n_nh = nh_sat;
                    if (hop_over) begin
                        n_st    = STAT_HOP_LIMIT;
                        n_state = ST_SEND;
                    end else if (r_carried[NODE_W-1]) begin
                        n_st    = STAT_PATH_END;
                        n_state = ST_SEND;
                    end else if (carried_bad) begin
                        n_st    = STAT_NO_LINK;
                        n_state = ST_SEND;
                    end else begin
                        nbr_re    = 1'b1;
                        nbr_raddr = RW'(r_carried[5:0]);
                        n_state   = ST_NBR_WAIT;
                    end
                end else begin
                    dest_re    = 1'b1;
                    dest_raddr = RW'(r_dest);
                    n_state    = ST_DEST_WAIT;
                end
            end
            ST_NBR_WAIT: begin
                if (nbr_rdata[NBR_W-1]) begin
                    n_st   = STAT_OK;
                    n_port = PORT_W'(nbr_rdata[NPW-1:0]);
                end else begin
                    n_st   = STAT_NO_LINK;
                    n_port = '0;
                end
                n_state = ST_SEND;
            end
            ST_DEST_WAIT: begin
                if (dest_cnt == '0) begin
                    n_st    = STAT_NO_PATH;
                    n_nh    = r_hops;
                    n_state = ST_SEND;
                end else begin
                    dest_we    = 1'b1;
                    dest_waddr = RW'(r_dest);
                    dest_wdata = {dest_cnt, sel_next};
                    n_base     = base_calc;
                    path_re    = 1'b1;
                    path_raddr = base_calc + SAW'(1);
                    n_vc       = '0;
                    n_nh       = HOP_W'(1);
                    n_i        = '0;
                    n_state    = ST_NODE1_WAIT;
                end
            end
            ST_NODE1_WAIT: begin
                n_port = '0;
                if (path_rdata[NODE_W-1]) begin
                    n_st       = STAT_PATH_END;
                    path_re    = 1'b1;
                    path_raddr = r_base;
                    n_state    = ST_PATH_WAIT;
                end else if (node1_bad) begin
                    n_st       = STAT_NO_LINK;
                    path_re    = 1'b1;
                    path_raddr = r_base;
                    n_state    = ST_PATH_WAIT;
                end else begin
                    nbr_re    = 1'b1;
                    nbr_raddr = RW'(path_rdata[5:0]);
                    n_state   = ST_NBR1_WAIT;
                end
            end
            ST_NBR1_WAIT: begin
                if (nbr_rdata[NBR_W-1]) begin
                    n_st   = STAT_OK;
                    n_port = PORT_W'(nbr_rdata[NPW-1:0]);
                end else begin
                    n_st   = STAT_NO_LINK;
                    n_port = '0;
                end
                path_re    = 1'b1;
                path_raddr = r_base;
                n_state    = ST_PATH_WAIT;
            end
            ST_PATH_WAIT: begin
                n_node  = path_rdata;
                n_last  = (r_i == eff_lim);
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i        = r_i + 1'b1;
                        path_re    = 1'b1;
                        path_raddr = r_base + SAW'(n_i);
                        n_state    = ST_PATH_WAIT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_ep       <= n_ep;
        r_hops     <= n_hops;
        r_carried  <= n_carried;
        r_tr       <= n_tr;
        r_ps       <= n_ps;
        r_hs       <= n_hs;
        r_tv       <= n_tv;
        r_dest     <= n_dest;
        r_rem      <= n_rem;
        r_base     <= n_base;
        r_i        <= n_i;
        r_port     <= n_port;
        r_vc       <= n_vc;
        r_nh       <= n_nh;
        r_node     <= n_node;
        r_st       <= n_st;
        r_last     <= n_last;
    end

    // output register
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'b0000, r_node, r_nh, r_vc, r_port};
            r_out_user <= r_st;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule
